// File: rtl/atp_pkg.sv
// Shared types and constants of the aging priority task picker.
// No dependencies; every other file in rtl but atp_ram imports this package.
package atp_pkg;

    localparam int PRIO_W   = 8;
    localparam int ID_W     = 4;
    localparam int ACTION_W = 2;
    localparam int NOW_W    = 40;

    // Priority weight 10^k reaches 10^11 for a 48-bit time, which fits 37 bits.
    localparam int SCALE_W = 37;
    localparam int K_W     = 4;
    localparam int NUM_THR = 11;
    localparam int NUM_POW = NUM_THR + 1;
    localparam int PROD_W  = PRIO_W + SCALE_W;

    // The weight steps up by ten each time now reaches 11 * 10^(j+3).
    localparam logic [63:0] DEC_THR [0:NUM_THR-1] = '{
        64'd11000,
        64'd110000,
        64'd1100000,
        64'd11000000,
        64'd110000000,
        64'd1100000000,
        64'd11000000000,
        64'd110000000000,
        64'd1100000000000,
        64'd11000000000000,
        64'd110000000000000
    };

    localparam logic [SCALE_W-1:0] POW10 [0:NUM_POW-1] = '{
        37'd1,
        37'd10,
        37'd100,
        37'd1000,
        37'd10000,
        37'd100000,
        37'd1000000,
        37'd10000000,
        37'd100000000,
        37'd1000000000,
        37'd10000000000,
        37'd100000000000
    };

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE  = 2'd0,
        ACT_REQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_PICK    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic in_vld;
        logic in_rdy;
    } scan_ctrl_t;

    typedef struct packed {
        logic busy;
        logic found;
    } scan_stat_t;

endpackage

// File: rtl/atp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module atp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/atp_scale.sv
// Priority weight unit: derives 10^k from the pick time over two registered steps.
// Depends on atp_pkg for the decade thresholds and the power-of-ten table.
module atp_scale import atp_pkg::*; #(
    parameter int TIME_BITS = 40
) (
    input  logic                 aclk,
    input  logic                 load,
    input  logic [TIME_BITS-1:0] now_in,
    output logic [SCALE_W-1:0]   scale
);

    logic [K_W-1:0]     k_reg;
    logic [K_W-1:0]     k_next;
    logic [SCALE_W-1:0] scale_reg;

    // Thresholds rise monotonically, so the last one passed gives the exponent.
    always_comb begin
        k_next = '0;
        for (int j = 0; j < NUM_THR; j++) begin
            if (64'(now_in) >= DEC_THR[j]) begin
                k_next = K_W'(j + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            k_reg <= k_next;
        end
        scale_reg <= POW10[k_reg];
    end

    assign scale = scale_reg;

endmodule

// File: rtl/atp_scan.sv
// Scoring pipeline: weights each slot read from the RAMs and keeps the best one.
// Depends on atp_pkg for the control and status structs and the widths.
module atp_scan import atp_pkg::*; #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 40,
    localparam int AW = $clog2(MAX_TASKS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_ctrl_t           ctrl,
    input  logic [AW-1:0]        in_idx,
    input  logic [PRIO_W-1:0]    rd_prio,
    input  logic [TIME_BITS-1:0] rd_time,
    input  logic [TIME_BITS-1:0] now,
    input  logic [SCALE_W-1:0]   scale,
    output scan_stat_t           stat,
    output logic [AW-1:0]        best_idx
);

    localparam int SCORE_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

    logic                 a_vld_reg;
    logic                 a_rdy_reg;
    logic [AW-1:0]        a_idx_reg;
    logic [TIME_BITS-1:0] a_delta_reg;
    logic [PROD_W-1:0]    a_prod_reg;

    logic                 best_vld_reg;
    logic [SCORE_W-1:0]   best_score_reg;
    logic [AW-1:0]        best_idx_reg;

    logic [SCORE_W-1:0]   score;
    logic                 take;

    // Stage A: age (wraps modulo the time width) and weighted priority.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= ctrl.in_vld;
        end
        a_rdy_reg   <= ctrl.in_rdy;
        a_idx_reg   <= in_idx;
        a_delta_reg <= now - rd_time;
        a_prod_reg  <= PROD_W'(rd_prio) * PROD_W'(scale);
    end

    // Stage B: the first ready slot is always taken; later ones need a strictly higher score.
    assign score = SCORE_W'(a_delta_reg) + SCORE_W'(a_prod_reg);
    assign take  = a_vld_reg && a_rdy_reg && (!best_vld_reg || (score > best_score_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_vld_reg <= 1'b0;
        end else if (ctrl.clear) begin
            best_vld_reg <= 1'b0;
        end else if (take) begin
            best_vld_reg <= 1'b1;
        end
        if (take) begin
            best_score_reg <= score;
            best_idx_reg   <= a_idx_reg;
        end
    end

    assign stat.busy  = ctrl.in_vld || a_vld_reg;
    assign stat.found = best_vld_reg;
    assign best_idx   = best_idx_reg;

endmodule

// File: rtl/aging_priority_task_picker.sv
// Aging priority task picker, top level. Create, requeue and remove items give their
// result in the cycle after acceptance. A pick passes a setup state, scans each slot on the
// single read port of the priority and last-run RAMs, drains the read and score stages and
// commits once the output is free; its result appears, and the next item is taken, after
// that commit. Reset (aresetn, synchronous, active low) clears the ready flags and control
// state; RAM contents stay, and the user must have them written before use (unchecked).
module aging_priority_task_picker import atp_pkg::*; #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 40
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ID_W-1:0]     s_task_id,
    input  logic [PRIO_W-1:0]   s_priority_req,
    input  logic [NOW_W-1:0]    s_now_time,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [ID_W-1:0]     m_chosen_task,
    output logic                m_found
);

    localparam int AW = $clog2(MAX_TASKS);

    // Control state.
    state_t                state_reg;
    state_t                state_next;
    logic [AW-1:0]         cnt_reg;
    logic [AW-1:0]         cnt_next;
    logic [MAX_TASKS-1:0]  slot_ready_reg;
    logic [MAX_TASKS-1:0]  slot_ready_next;
    logic                  issue_vld_reg;
    logic                  issue_vld_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;

    // Payload registers.
    logic                  issue_rdy_reg;
    logic [AW-1:0]         issue_idx_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [ID_W-1:0]       m_chosen_task_reg;
    logic [ID_W-1:0]       m_chosen_task_next;
    logic                  m_found_reg;
    logic                  m_found_next;

    // Handshake and decode.
    action_t               act;
    logic                  s_accept;
    logic                  out_free;
    logic                  id_ok;
    logic [AW-1:0]         id_addr;
    logic [TIME_BITS-1:0]  now_in;

    // RAM ports.
    logic                  prio_we;
    logic                  time_we;
    logic [AW-1:0]         time_waddr;
    logic [TIME_BITS-1:0]  time_wdata;
    logic                  rd_en;
    logic [PRIO_W-1:0]     rd_prio;
    logic [TIME_BITS-1:0]  rd_time;

    // Scan and scale units.
    scan_ctrl_t            scan_ctrl;
    scan_stat_t            scan_stat;
    logic [AW-1:0]         best_idx;
    logic [SCALE_W-1:0]    scale;
    logic                  scale_load;
    logic                  pick_commit;

    assign act      = action_t'(s_action);
    assign out_free = !m_valid_reg || m_ready;
    // A pick may be taken while an earlier result still waits, since it does not
    // write the output register until its scan has finished.
    assign s_ready  = (state_reg == ST_IDLE) && (out_free || (act == ACT_PICK));
    assign s_accept = s_valid && s_ready;
    assign id_ok    = 32'(s_task_id) < 32'(MAX_TASKS);
    assign id_addr  = AW'(s_task_id);
    assign now_in   = TIME_BITS'(s_now_time);

    assign scale_load  = s_accept && (act == ACT_PICK);
    assign pick_commit = (state_reg == ST_DONE) && out_free && scan_stat.found;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            slot_ready_reg <= '0;
            issue_vld_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            slot_ready_reg <= slot_ready_next;
            issue_vld_reg  <= issue_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        issue_rdy_reg     <= slot_ready_reg[cnt_reg];
        issue_idx_reg     <= cnt_reg;
        m_chosen_task_reg <= m_chosen_task_next;
        m_found_reg       <= m_found_next;
        if (scale_load) begin
            now_reg <= now_in;
        end
    end

    // Sequencer: next state, scan control, table writes and the output register.
    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        slot_ready_next    = slot_ready_reg;
        issue_vld_next     = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_chosen_task_next = m_chosen_task_reg;
        m_found_next       = m_found_reg;
        scan_ctrl.clear    = 1'b0;
        scan_ctrl.in_vld   = issue_vld_reg;
        scan_ctrl.in_rdy   = issue_rdy_reg;
        rd_en              = 1'b0;
        prio_we            = 1'b0;
        time_we            = 1'b0;
        time_waddr         = id_addr;
        time_wdata         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (act == ACT_PICK) begin
                        state_next = ST_SETUP;
                        cnt_next   = '0;
                    end else begin
                        // Table actions answer at once with an empty result.
                        m_valid_next       = 1'b1;
                        m_chosen_task_next = '0;
                        m_found_next       = 1'b0;
                        if (id_ok) begin
                            unique case (act)
                                ACT_CREATE: begin
                                    slot_ready_next[id_addr] = 1'b1;
                                    prio_we                  = 1'b1;
                                    time_we                  = 1'b1;
                                end
                                ACT_REQUEUE: begin
                                    slot_ready_next[id_addr] = 1'b1;
                                    prio_we                  = 1'b1;
                                end
                                ACT_REMOVE: begin
                                    slot_ready_next[id_addr] = 1'b0;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
            ST_SETUP: begin
                // The weight settles in the scale unit while the best slot is cleared.
                scan_ctrl.clear = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                rd_en          = 1'b1;
                issue_vld_next = 1'b1;
                cnt_next       = cnt_reg + AW'(1);
                if (cnt_reg == AW'(MAX_TASKS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!scan_stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next         = ST_IDLE;
                    m_valid_next       = 1'b1;
                    m_found_next       = scan_stat.found;
                    m_chosen_task_next = scan_stat.found ? ID_W'(best_idx) : '0;
                    if (scan_stat.found) begin
                        // Dequeue the winner and stamp it with the pick time.
                        slot_ready_next[best_idx] = 1'b0;
                        time_we                   = 1'b1;
                        time_waddr                = best_idx;
                        time_wdata                = now_reg;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    atp_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (MAX_TASKS)
    ) u_prio_ram (
        .aclk  (aclk),
        .we    (prio_we),
        .waddr (id_addr),
        .wdata (s_priority_req),
        .re    (rd_en),
        .raddr (cnt_reg),
        .rdata (rd_prio)
    );

    atp_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_TASKS)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .re    (rd_en),
        .raddr (cnt_reg),
        .rdata (rd_time)
    );

    atp_scale #(
        .TIME_BITS (TIME_BITS)
    ) u_scale (
        .aclk   (aclk),
        .load   (scale_load),
        .now_in (now_in),
        .scale  (scale)
    );

    atp_scan #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (scan_ctrl),
        .in_idx   (issue_idx_reg),
        .rd_prio  (rd_prio),
        .rd_time  (rd_time),
        .now      (now_reg),
        .scale    (scale),
        .stat     (scan_stat),
        .best_idx (best_idx)
    );

    assign m_valid       = m_valid_reg;
    assign m_chosen_task = m_chosen_task_reg;
    assign m_found       = m_found_reg;

    // A result without a found task always reports slot zero.
    a_empty_pick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_chosen_task == '0))
        else $error("result without a found task reports a nonzero slot");

    // The last-run RAM is never written while the scan reads it.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) |-> !time_we)
        else $error("last-run RAM written during a scan");

    // A committed pick leaves its winner dequeued.
    a_winner_dequeued: assert property (@(posedge aclk) disable iff (!aresetn)
        pick_commit |=> !slot_ready_reg[$past(best_idx)])
        else $error("picked slot still ready after commit");

endmodule

// File: dv/aging_priority_task_picker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for aging_priority_task_picker: a directed table of task items,
// then random create, requeue, remove and pick items checked against an in-bench predictor.
// Depends on rtl/atp_pkg.sv and rtl/aging_priority_task_picker.sv.
module aging_priority_task_picker_tb;
    import atp_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int RANDOM_ITEMS   = 600;
    localparam int NUM_DIRECTED   = 24;
    // Longest legal quiet spell is the receiver hold-off plus one pick; take it many times.
    localparam int WATCHDOG_LIMIT = 3000;
    // A pick returns its result only after its scan and drain have finished.
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    // Burst and hold windows: accepted items, both sides paced. PAUSE_AT: random items.
    localparam int BURST_LO       = 100;
    localparam int BURST_HI       = 180;
    localparam int HOLD_AT        = 350;
    localparam int PAUSE_AT       = 450;
    localparam logic [63:0] TICKS_PER_MS = 64'd1000;
    localparam logic [63:0] DECADE       = 64'd10;

    localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0] slot;
        logic            found;
    } outcome_t;

    // One row of directed stimulus. When typed is set, want_slot and want_found are the
    // expected result; otherwise the predictor supplies it.
    typedef struct packed {
        action_t           act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [NOW_W-1:0]  t;
        logic              typed;
        logic [ID_W-1:0]   want_slot;
        logic              want_found;
    } stim_row_t;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // A pick straight after reset finds nothing.
        '{ACT_PICK,    4'd0,  8'd0,   40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd0,  8'd0,   40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd15, 8'd255, TIME_MAX,          1'b1, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd0,             1'b0, 4'd0, 1'b0},
        // Only slot 0 is left and its score is zero: it must still be picked.
        '{ACT_PICK,    4'd0,  8'd0,   40'd0,             1'b0, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd0,             1'b1, 4'd0, 1'b0},
        // Equal scores: the lower slot wins. 10999 is the last tick with unit weight.
        '{ACT_CREATE,  4'd3,  8'd10,  40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd5,  8'd10,  40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd10999,         1'b0, 4'd0, 1'b0},
        // Requeue keeps the last-run time, then time steps backwards and the age wraps.
        '{ACT_REQUEUE, 4'd3,  8'd10,  40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd500,           1'b0, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd11000,         1'b0, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd7,  8'd1,   40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_REMOVE,  4'd7,  8'd0,   40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd5,             1'b1, 4'd0, 1'b0},
        '{ACT_REQUEUE, 4'd15, 8'd0,   40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd10, 8'd255, 40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_REQUEUE, 4'd5,  8'd200, 40'd0,             1'b1, 4'd0, 1'b0},
        // Largest time, then alternating bit patterns of the time field.
        '{ACT_PICK,    4'd0,  8'd0,   TIME_MAX,          1'b0, 4'd0, 1'b0},
        '{ACT_PICK,    4'd9,  8'd85,  40'h55_5555_5555,  1'b0, 4'd0, 1'b0},
        '{ACT_PICK,    4'd6,  8'd170, 40'hAA_AAAA_AAAA,  1'b0, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd9,  8'd128, 40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_CREATE,  4'd6,  8'd127, 40'd0,             1'b1, 4'd0, 1'b0},
        '{ACT_PICK,    4'd0,  8'd0,   40'd1000000,       1'b0, 4'd0, 1'b0}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action;
    logic [ID_W-1:0]     s_task_id;
    logic [PRIO_W-1:0]   s_priority_req;
    logic [NOW_W-1:0]    s_now_time;
    logic                m_valid;
    logic                m_ready;
    logic [ID_W-1:0]     m_chosen_task;
    logic                m_found;

    // Predictor copy of the slot table. stamp_known marks slots whose last-run time has
    // been written by a create or a pick, so requeues can be steered away from the rest.
    logic              slot_live   [NUM_SLOTS];
    logic [PRIO_W-1:0] slot_prio   [NUM_SLOTS];
    logic [NOW_W-1:0]  slot_stamp  [NUM_SLOTS];
    logic              stamp_known [NUM_SLOTS];

    outcome_t pending_outcomes [$];
    int       items_sent  = 0;
    int       mismatches  = 0;
    int       idle_cycles = 0;

    aging_priority_task_picker u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_task_id      (s_task_id),
        .s_priority_req (s_priority_req),
        .s_now_time     (s_now_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chosen_task  (m_chosen_task),
        .m_found        (m_found)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Priority weight: divide the millisecond count by ten until it is at most ten,
    // growing the weight tenfold per division.
    function automatic logic [63:0] priority_scale(input logic [NOW_W-1:0] t);
        logic [63:0] q;
        logic [63:0] w;
        q = 64'(t) / TICKS_PER_MS;
        w = 64'd1;
        while (q > DECADE) begin
            q = q / DECADE;
            w = w * DECADE;
        end
        return w;
    endfunction

    // Applies one task action to the predictor table and returns the result it gives.
    function automatic void schedule_action(input action_t act, input logic [ID_W-1:0] id,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [NOW_W-1:0] t,
                                            output outcome_t res);
        logic [63:0]      weight;
        logic [63:0]      score;
        logic [63:0]      best;
        logic [NOW_W-1:0] age;
        int               winner;
        res = '0;
        case (act)
            ACT_CREATE: begin
                slot_live[id]   = 1'b1;
                slot_prio[id]   = prio;
                slot_stamp[id]  = '0;
                stamp_known[id] = 1'b1;
            end
            ACT_REQUEUE: begin
                slot_live[id] = 1'b1;
                slot_prio[id] = prio;
            end
            ACT_REMOVE: begin
                slot_live[id] = 1'b0;
            end
            default: begin
                weight = priority_scale(t);
                best   = '0;
                winner = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_live[i]) begin
                        // The age wraps at the time width, like a free-running counter.
                        age   = t - slot_stamp[i];
                        score = 64'(age) + 64'(slot_prio[i]) * weight;
                        // Only a strictly higher score displaces the first ready slot.
                        if (winner < 0 || score > best) begin
                            best   = score;
                            winner = i;
                        end
                    end
                end
                if (winner >= 0) begin
                    slot_live[winner]   = 1'b0;
                    slot_stamp[winner]  = t;
                    stamp_known[winner] = 1'b1;
                    res.slot            = ID_W'(winner);
                    res.found           = 1'b1;
                end
            end
        endcase
    endfunction

    // Offers one item and holds it until accepted, then records what it should return.
    task automatic offer_item(input action_t act, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio, input logic [NOW_W-1:0] t,
                              input logic typed, input outcome_t want);
        outcome_t res;
        s_valid        <= 1'b1;
        s_action       <= act;
        s_task_id      <= id;
        s_priority_req <= prio;
        s_now_time     <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        schedule_action(act, id, prio, t, res);
        pending_outcomes.push_back(typed ? want : res);
        items_sent++;
    endtask

    // Sender idling: mostly back to back, sometimes a short gap, rarely a long one.
    // The burst window and the window around the receiver hold-off run with no gaps.
    task automatic sender_gap();
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if ((items_sent >= BURST_LO && items_sent < BURST_HI) ||
            (items_sent >= HOLD_AT && items_sent < HOLD_AT + 40)) begin
            gap = 0;
        end else if (r < 25) begin
            gap = $urandom_range(1, 3);
        end else if (r < 30) begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver pacing. Each branch sets m_ready once and then lets at least one edge pass.
    // Once, after HOLD_AT items, it refuses results for a long stretch so the block backs
    // up and stalls its input while the sender keeps offering.
    initial begin
        int r;
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (items_sent >= BURST_LO && items_sent < BURST_HI) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge aclk);
                end
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result: chosen_task %0d found %0d",
                         $time, m_chosen_task, m_found);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_chosen_task !== want.slot) begin
                    $display("%0t: chosen_task expected %0d got %0d",
                             $time, want.slot, m_chosen_task);
                    mismatches++;
                end
                if (m_found !== want.found) begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, m_found);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: reset, the directed table, then the random part.
    initial begin
        int               r;
        int               m;
        action_t          act;
        logic [ID_W-1:0]  id;
        logic [PRIO_W-1:0] prio;
        logic [NOW_W-1:0] tick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_CREATE;
        s_task_id      = '0;
        s_priority_req = '0;
        s_now_time     = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_prio[i]   = '0;
            slot_stamp[i]  = '0;
            stamp_known[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            offer_item(DIRECTED[i].act, DIRECTED[i].id, DIRECTED[i].prio, DIRECTED[i].t,
                       DIRECTED[i].typed, {DIRECTED[i].want_slot, DIRECTED[i].want_found});
            sender_gap();
        end

        // Random part. Time mostly moves forward in modest steps so ages and weights stay
        // comparable; sometimes it jumps anywhere in the 40-bit range or steps backwards.
        tick = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r  = $urandom_range(0, 99);
            id = ID_W'($urandom_range(0, NUM_SLOTS - 1));
            if (r < 30) begin
                act = ACT_CREATE;
            end else if (r < 50) begin
                act = ACT_REQUEUE;
            end else if (r < 65) begin
                act = ACT_REMOVE;
            end else begin
                act = ACT_PICK;
            end
            // A requeue may only land on a slot whose last-run time has been written;
            // walk to the next such slot, or turn it into a create if there is none.
            if (act == ACT_REQUEUE) begin
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (!stamp_known[id]) id = id + 1'b1;
                end
                if (!stamp_known[id]) act = ACT_CREATE;
            end
            m = $urandom_range(0, 99);
            if (m < 10) begin
                prio = '0;
            end else if (m < 20) begin
                prio = '1;
            end else begin
                prio = PRIO_W'($urandom);
            end
            m = $urandom_range(0, 99);
            if (m < 50) begin
                tick = tick + NOW_W'($urandom_range(0, 4000));
            end else if (m < 65) begin
                tick = NOW_W'($urandom_range(0, 30000));
            end else if (m < 85) begin
                tick = NOW_W'({$urandom, $urandom});
            end else begin
                tick = tick - NOW_W'($urandom_range(0, 2000));
            end
            // Once, the sender stops and waits until every expected result is back.
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_outcomes.size() != 0);
            end
            offer_item(act, id, prio, tick, 1'b0, '0);
            sender_gap();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
